[src/jfhe_pkg.sv]
// Package for the JPEG frame header extractor.
// Holds the transfer and result types, parse phases, status codes and marker constants.
// No dependencies.
package jfhe_pkg;

    // One input byte with its end-of-buffer flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_item;

    // Outcome codes for a buffer.
    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_NOTJPEG  = 3'd1,
        ST_STOP     = 3'd2,
        ST_BADLEN   = 3'd3,
        ST_TRUNC    = 3'd4,
        ST_SHORTSOF = 3'd5
    } t_status;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [15:0] bits_per_pixel;
    } t_result;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SIG   = 3'd0,
        PH_FFRUN = 3'd1,
        PH_SEEK  = 3'd2,
        PH_LENHI = 3'd3,
        PH_LENLO = 3'd4,
        PH_BODY  = 3'd5
    } t_phase;

    // Marker byte values.
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_SOS    = 8'hDA;
    localparam logic [7:0] MARK_RST0   = 8'hD0;
    localparam logic [7:0] MARK_RST7   = 8'hD7;
    localparam logic [7:0] MARK_SOF0   = 8'hC0;

    // Smallest frame-start segment length that holds all captured fields.
    localparam logic [15:0] SOF_MIN_LEN = 16'd8;

    // Expected signature bytes, FF D8 FF.
    localparam logic [7:0] SIG_BYTES [3] = '{8'hFF, 8'hD8, 8'hFF};

    // Frame-start markers: C0, or C1..CF with nonzero low two bits.
    function automatic logic is_frame_start(input logic [7:0] m);
        logic hit;
        hit = (m == MARK_SOF0) ||
              ((m > MARK_SOF0) && (m < MARK_RST0) && (m[1:0] != 2'b00));
        return hit;
    endfunction

endpackage

[src/jpeg_frame_header_extractor.sv]
// JPEG frame header extractor, top level.
// Input byte channel and result channel, both valid/stall, with the JPEG start-of-frame
// walk between an input register and a result register.
//
// Usage: feed one buffer as a stream of byte transfers on i_data_byte, with
// i_final_byte high on its last byte. Each buffer yields exactly one result
// transfer: o_status, and for status found the frame size and bits per pixel.
// The result comes on the byte that decides it (signature mismatch, stop
// marker, bad length, end of a frame-start segment) or on the final byte.
// Bytes after the result are dropped up to and including the final byte.
// Path: a byte accepted into the input register is parsed into the result
// register, from which its result can transfer to the receiver.
// Throughput: one byte per cycle while no held result is stalled, set by the
// parse step between the input register and the result register.
// Reset: synchronous, active low; clears both stages and puts the parser at
// the first signature byte.
// Receiver stall: a held result blocks the parser; one more byte waits in the
// input register, then o_stall rises until the result is taken.
// Depends on jfhe_pkg, jfhe_in_reg, jfhe_parser and jfhe_out_reg.
module jpeg_frame_header_extractor
    import jfhe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_frame_width,
    output logic [15:0] o_frame_height,
    output logic [15:0] o_bits_per_pixel
);

    t_item   in_item;
    t_item   s1_item;
    logic    s1_full;
    logic    go;
    logic    out_ready;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item.data_byte  = i_data_byte;
    assign in_item.final_byte = i_final_byte;

    // The parser steps whenever a byte is held and the result register is free.
    assign go = s1_full && out_ready;

    jfhe_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_take  (go),
        .o_stall (o_stall),
        .o_full  (s1_full),
        .o_item  (s1_item)
    );

    jfhe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_item      (s1_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    jfhe_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (go && res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_status         = out_res.status;
    assign o_frame_width    = out_res.frame_width;
    assign o_frame_height   = out_res.frame_height;
    assign o_bits_per_pixel = out_res.bits_per_pixel;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall && s1_full)
        else $error("input stalled without a held result");

    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && s1_item.final_byte && res_valid |=> o_valid)
        else $error("final byte result not registered");

    a_stall_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_full && !i_stall |-> go)
        else $error("parser idle while the receiver is ready");

endmodule

[src/jfhe_in_reg.sv]
// Input register stage of the JPEG frame header extractor.
// Captures one byte transfer and holds it until the parser takes it.
// Depends on jfhe_pkg.
module jfhe_in_reg
    import jfhe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_stall,
    output logic  o_full,
    output t_item o_item
);

    logic  r_full;
    logic  n_full;
    t_item r_item;
    logic  accept;

    // The stage is blocked only when it holds a byte the parser cannot take.
    assign o_stall = r_full && !i_take;
    assign accept  = i_valid && !o_stall;

    // Occupancy follows transfers in and out.
    always_comb begin
        n_full = r_full;
        if (accept) begin
            n_full = 1'b1;
        end else if (i_take) begin
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_full = r_full;
    assign o_item = r_item;

    a_take_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_full) else $error("parser took from an empty input stage");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full && !i_take |=> r_full && $stable(r_item))
        else $error("blocked input byte was lost or changed");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_full) else $error("accepted byte not held");

endmodule

[src/jfhe_parser.sv]
// Marker segment parser of the JPEG frame header extractor.
// Holds the parse state, steps it once per byte and forms the buffer result.
// Depends on jfhe_pkg.
module jfhe_parser
    import jfhe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    t_phase      r_phase, n_phase, step_phase;
    logic [1:0]  r_sig_idx, n_sig_idx;
    logic [7:0]  r_marker, n_marker;
    logic [15:0] r_len, n_len;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_prec, n_prec;
    logic [15:0] r_height, n_height;
    logic [15:0] r_width, n_width;
    logic [15:0] r_bpp, n_bpp;
    logic        r_concluded, n_concluded;

    logic        hit;
    t_status     hit_st;
    logic        res_any;
    logic [7:0]  b;
    logic        fin;
    logic [15:0] len_full;
    logic [15:0] pos;

    assign b        = i_item.data_byte;
    assign fin      = i_item.final_byte;
    assign len_full = {r_len[15:8], b};
    assign pos      = r_len - r_left;

    // Next state: one parse step for the byte in the input register.
    always_comb begin
        step_phase  = r_phase;
        n_sig_idx   = r_sig_idx;
        n_marker    = r_marker;
        n_len       = r_len;
        n_left      = r_left;
        n_prec      = r_prec;
        n_height    = r_height;
        n_width     = r_width;
        n_bpp       = r_bpp;
        n_concluded = r_concluded;
        hit         = 1'b0;
        hit_st      = ST_FOUND;

        if (!r_concluded) begin
            case (r_phase)
                PH_SIG: begin
                    if (b != SIG_BYTES[r_sig_idx]) begin
                        hit    = 1'b1;
                        hit_st = ST_NOTJPEG;
                    end else if (r_sig_idx == 2'd2) begin
                        step_phase = PH_FFRUN;
                    end else begin
                        n_sig_idx = r_sig_idx + 2'd1;
                    end
                end
                PH_SEEK: begin
                    if (b == MARK_PREFIX) begin
                        step_phase = PH_FFRUN;
                    end
                end
                PH_FFRUN: begin
                    // Fill bytes keep the run; a marker on the final byte truncates.
                    if (b != MARK_PREFIX && !fin) begin
                        if (b >= MARK_SOI && b <= MARK_SOS) begin
                            hit    = 1'b1;
                            hit_st = ST_STOP;
                        end else if (b >= MARK_RST0 && b <= MARK_RST7) begin
                            step_phase = PH_SEEK;
                        end else begin
                            n_marker   = b;
                            step_phase = PH_LENHI;
                        end
                    end
                end
                PH_LENHI: begin
                    n_len      = {b, 8'h00};
                    step_phase = PH_LENLO;
                end
                PH_LENLO: begin
                    n_len = len_full;
                    if (len_full < 16'd2) begin
                        hit    = 1'b1;
                        hit_st = ST_BADLEN;
                    end else begin
                        n_left = len_full - 16'd2;
                        if (len_full == 16'd2) begin
                            // Empty segment ends here.
                            if (is_frame_start(r_marker)) begin
                                hit    = 1'b1;
                                hit_st = (len_full >= SOF_MIN_LEN) ? ST_FOUND : ST_SHORTSOF;
                            end else begin
                                step_phase = PH_SEEK;
                            end
                        end else begin
                            step_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    // Capture frame-start fields by their offset in the segment.
                    case (pos)
                        16'd2: n_prec = b;
                        16'd3: n_height = {b, r_height[7:0]};
                        16'd4: n_height = {r_height[15:8], b};
                        16'd5: n_width = {b, r_width[7:0]};
                        16'd6: n_width = {r_width[15:8], b};
                        16'd7: n_bpp = 16'(r_prec) * 16'(b);
                        default: n_bpp = r_bpp;
                    endcase
                    n_left = r_left - 16'd1;
                    if (r_left == 16'd1) begin
                        if (is_frame_start(r_marker)) begin
                            hit    = 1'b1;
                            hit_st = (r_len >= SOF_MIN_LEN) ? ST_FOUND : ST_SHORTSOF;
                        end else begin
                            step_phase = PH_SEEK;
                        end
                    end
                end
                default: begin
                    step_phase = PH_SIG;
                end
            endcase
        end

        res_any = !r_concluded && (hit || fin);

        // The final byte always starts the next buffer afresh.
        n_phase = step_phase;
        if (fin) begin
            n_phase     = PH_SIG;
            n_sig_idx   = 2'd0;
            n_concluded = 1'b0;
        end else if (res_any) begin
            n_concluded = 1'b1;
        end
    end

    // Outputs: the result for this byte, if it decides the buffer.
    always_comb begin
        o_res_valid = res_any;
        o_res       = '0;
        if (hit) begin
            o_res.status = hit_st;
        end else if (step_phase == PH_SIG) begin
            o_res.status = ST_NOTJPEG;
        end else begin
            o_res.status = ST_TRUNC;
        end
        if (hit && hit_st == ST_FOUND) begin
            o_res.frame_width    = r_width;
            o_res.frame_height   = r_height;
            o_res.bits_per_pixel = n_bpp;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIG;
            r_sig_idx   <= 2'd0;
            r_concluded <= 1'b0;
        end else if (i_go) begin
            r_phase     <= n_phase;
            r_sig_idx   <= n_sig_idx;
            r_concluded <= n_concluded;
        end
    end

    // Segment and frame-start datapath; always written before it is read.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_marker <= n_marker;
            r_len    <= n_len;
            r_left   <= n_left;
            r_prec   <= n_prec;
            r_height <= n_height;
            r_width  <= n_width;
            r_bpp    <= n_bpp;
        end
    end

    a_final_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && i_item.final_byte |=> r_phase == PH_SIG && !r_concluded && r_sig_idx == 2'd0)
        else $error("final byte did not restart the parser");

    a_concluded_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && r_concluded && !i_item.final_byte |=> r_concluded && !$past(o_res_valid))
        else $error("bytes after the result were not ignored");

    a_length_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && r_phase == PH_LENHI && !r_concluded && !i_item.final_byte |=> r_phase == PH_LENLO)
        else $error("length high byte not followed by low byte");

endmodule

[src/jfhe_out_reg.sv]
// Result register of the JPEG frame header extractor.
// Holds one result item until the receiver takes it.
// Depends on jfhe_pkg.
module jfhe_out_reg
    import jfhe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Free when empty or when the held result leaves this cycle.
    assign o_ready = !(r_valid && i_stall);

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready) else $error("result overwritten while held");

    a_zero_unless_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.status != ST_FOUND |->
            r_res.frame_width == 16'd0 && r_res.frame_height == 16'd0 &&
            r_res.bits_per_pixel == 16'd0)
        else $error("frame fields nonzero without a found status");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_res))
        else $error("stalled result changed");

endmodule

[sim/jfhe_checker.sv]
// Checker for the JPEG frame header extractor: follows byte and result transfers,
// predicts the header outcome of every buffer and compares each result field by field.
// Depends on jfhe_pkg for the status and phase enums and the marker constants.
module jfhe_checker
    import jfhe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [15:0] i_frame_width,
    input  logic [15:0] i_frame_height,
    input  logic [15:0] i_bits_per_pixel,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser state as the block should hold it.
    t_phase      phase;
    logic [1:0]  sig_idx;
    logic [7:0]  marker;
    logic [15:0] seg_len;
    logic [15:0] seg_left;
    logic [7:0]  precision;
    logic [15:0] height;
    logic [15:0] width;
    logic [7:0]  components;
    logic        done;

    // Header outcomes predicted but not yet seen on the result channel.
    t_result due_headers_q[$];
    int      fails;

    function automatic void clear_parser();
        phase      = PH_SIG;
        sig_idx    = 2'd0;
        marker     = 8'h00;
        seg_len    = 16'h0000;
        seg_left   = 16'h0000;
        precision  = 8'h00;
        height     = 16'h0000;
        width      = 16'h0000;
        components = 8'h00;
        done       = 1'b0;
    endfunction

    // Frame-start markers: C0, and C1..CF unless the low two bits are zero.
    function automatic logic sof_marker(input logic [7:0] m);
        return (m[7:4] == 4'hC) && ((m[3:0] == 4'h0) || (m[1:0] != 2'b00));
    endfunction

    // Advance the parser by one byte and queue the outcome if this byte decides one.
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        t_status     st;
        logic        decided;
        logic        seg_end;
        logic [15:0] pos;
        t_result     r;
        decided = 1'b0;
        seg_end = 1'b0;
        st      = ST_TRUNC;
        if (done) begin
            // Bytes after the outcome are dropped; the final byte rearms the parser.
            if (fin) clear_parser();
        end else begin
            case (phase)
                PH_SIG: begin
                    if (b != SIG_BYTES[sig_idx]) begin
                        decided = 1'b1;
                        st      = ST_NOTJPEG;
                    end else if (sig_idx == 2'd2) begin
                        phase = PH_FFRUN;
                    end else begin
                        sig_idx = sig_idx + 2'd1;
                    end
                end
                PH_SEEK: begin
                    if (b == MARK_PREFIX) phase = PH_FFRUN;
                end
                PH_FFRUN: begin
                    // Fill bytes keep us here; a marker on the final byte is a truncation.
                    if (b != MARK_PREFIX && !fin) begin
                        if (b >= MARK_SOI && b <= MARK_SOS) begin
                            decided = 1'b1;
                            st      = ST_STOP;
                        end else if (b >= MARK_RST0 && b <= MARK_RST7) begin
                            phase = PH_SEEK;
                        end else begin
                            marker = b;
                            phase  = PH_LENHI;
                        end
                    end
                end
                PH_LENHI: begin
                    seg_len = {b, 8'h00};
                    phase   = PH_LENLO;
                end
                PH_LENLO: begin
                    seg_len[7:0] = b;
                    if (seg_len < 16'd2) begin
                        decided = 1'b1;
                        st      = ST_BADLEN;
                    end else begin
                        seg_left = seg_len - 16'd2;
                        if (seg_left == 16'd0) seg_end = 1'b1;
                        else phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    // Offsets count from the start of the length field.
                    pos = seg_len - seg_left;
                    case (pos)
                        16'd2: precision = b;
                        16'd3: height[15:8] = b;
                        16'd4: height[7:0] = b;
                        16'd5: width[15:8] = b;
                        16'd6: width[7:0] = b;
                        16'd7: components = b;
                        default: ;
                    endcase
                    seg_left = seg_left - 16'd1;
                    if (seg_left == 16'd0) seg_end = 1'b1;
                end
                default: ;
            endcase

            // A complete frame-start segment decides; any other segment resumes the walk.
            if (seg_end) begin
                if (sof_marker(marker)) begin
                    decided = 1'b1;
                    st      = (seg_len >= SOF_MIN_LEN) ? ST_FOUND : ST_SHORTSOF;
                end else begin
                    phase = PH_SEEK;
                end
            end

            if (!decided && fin) begin
                decided = 1'b1;
                st      = (phase == PH_SIG) ? ST_NOTJPEG : ST_TRUNC;
            end

            if (decided) begin
                r.status         = st;
                r.frame_width    = 16'h0000;
                r.frame_height   = 16'h0000;
                r.bits_per_pixel = 16'h0000;
                if (st == ST_FOUND) begin
                    r.frame_width    = width;
                    r.frame_height   = height;
                    r.bits_per_pixel = {8'h00, precision} * {8'h00, components};
                end
                due_headers_q.push_back(r);
                if (fin) clear_parser();
                else done = 1'b1;
            end
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    // Predict on byte transfers, compare on result transfers.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_parser();
            due_headers_q.delete();
            fails = 0;
        end else begin
            if (i_in_valid && !i_in_stall) parse_byte(i_data_byte, i_final_byte);
            if (i_out_valid && !i_out_stall) begin
                if (due_headers_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, i_status);
                    fails++;
                end else begin
                    want = due_headers_q.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("frame_width", want.frame_width, i_frame_width);
                    check_field("frame_height", want.frame_height, i_frame_height);
                    check_field("bits_per_pixel", want.bits_per_pixel, i_bits_per_pixel);
                end
            end
        end
        o_pending    <= due_headers_q.size();
        o_fail_count <= fails;
    end

endmodule

[sim/testbench.sv]
// Top of the JPEG frame header extractor testbench: clock, reset, byte stimulus,
// random receiver stall, watchdog and verdict.
// Depends on jfhe_pkg, jpeg_frame_header_extractor and jfhe_checker.
module testbench
    import jfhe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Filler segment markers used to build well-formed buffers.
    localparam logic [7:0] MARK_APP0 = 8'hE0;
    localparam logic [7:0] MARK_DHT  = 8'hC4;
    localparam logic [7:0] MARK_DQT  = 8'hDB;
    localparam logic [7:0] MARK_COM  = 8'hFE;
    localparam logic [7:0] MARK_ZERO = 8'h00;

    localparam int QUIET_LIMIT = 2000;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte  = 8'h00;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [2:0]  status;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [15:0] bits_per_pixel;
    int          fail_count;
    int          pending;

    int          idle_pct   = 0;
    int          stall_pct  = 0;
    int          byte_count = 0;
    int          quiet_cycles = 0;
    logic [7:0]  image_q[$];

    jpeg_frame_header_extractor dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_data_byte      (data_byte),
        .i_final_byte     (final_byte),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_status         (status),
        .o_frame_width    (frame_width),
        .o_frame_height   (frame_height),
        .o_bits_per_pixel (bits_per_pixel)
    );

    jfhe_checker u_header_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_data_byte      (data_byte),
        .i_final_byte     (final_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_status         (status),
        .i_frame_width    (frame_width),
        .i_frame_height   (frame_height),
        .i_bits_per_pixel (bits_per_pixel),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Random receiver stall.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // End the run when no transfer happens on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One byte transfer, after a random number of idle cycles.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        final_byte <= fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        byte_count++;
    endtask

    task automatic send_image();
        int k;
        for (k = 0; k < image_q.size(); k++) send_byte(image_q[k], k == image_q.size() - 1);
    endtask

    // Marker, length and body; the first six body bytes carry the frame-start fields.
    task automatic add_segment(input logic [7:0] m, input logic [15:0] len,
                               input logic [7:0] prec, input logic [15:0] h,
                               input logic [15:0] w, input logic [7:0] comp);
        logic [7:0] fields [6];
        int         k;
        fields = '{prec, h[15:8], h[7:0], w[15:8], w[7:0], comp};
        image_q.push_back(MARK_PREFIX);
        image_q.push_back(m);
        image_q.push_back(len[15:8]);
        image_q.push_back(len[7:0]);
        for (k = 2; k < len; k++) begin
            image_q.push_back((k < 8) ? fields[k - 2] : 8'($urandom_range(255)));
        end
    endtask

    function automatic logic [7:0] filler_marker();
        logic [7:0] m;
        case ($urandom_range(5))
            0: m = MARK_APP0 + 8'($urandom_range(15));
            1: m = MARK_DHT + 8'($urandom_range(2) * 4);
            2: m = MARK_DQT;
            3: m = MARK_COM;
            4: m = MARK_ZERO;
            default: m = 8'($urandom_range(254));
        endcase
        return m;
    endfunction

    function automatic logic [7:0] frame_marker();
        logic [7:0] m;
        do m = MARK_SOF0 + 8'($urandom_range(15));
        while (m != MARK_SOF0 && m[1:0] == 2'b00);
        return m;
    endfunction

    // Mostly well-formed buffers with random content, the rest bad lengths,
    // corrupt signatures and noise.
    task automatic build_random_image();
        int          kind;
        int          cut;
        int          idx;
        logic [15:0] len;
        image_q.delete();
        kind = $urandom_range(99);
        if (kind >= 85) begin
            repeat ($urandom_range(12, 1)) image_q.push_back(8'($urandom_range(255)));
        end else begin
            image_q.push_back(MARK_PREFIX);
            image_q.push_back(MARK_SOI);
            repeat ($urandom_range(3)) begin
                if ($urandom_range(3) == 0) image_q.push_back(MARK_PREFIX);
                if ($urandom_range(5) == 0) begin
                    image_q.push_back(MARK_PREFIX);
                    image_q.push_back(MARK_RST0 + 8'($urandom_range(7)));
                end else begin
                    len = ($urandom_range(49) == 0) ? 16'($urandom_range(300, 256))
                                                    : 16'($urandom_range(20, 2));
                    add_segment(filler_marker(), len, 8'($urandom_range(255)),
                                16'($urandom), 16'($urandom), 8'($urandom_range(255)));
                end
                // Stray bytes between segments are skipped while seeking.
                if ($urandom_range(4) == 0) begin
                    repeat ($urandom_range(3, 1)) image_q.push_back(8'($urandom_range(254)));
                end
            end

            if (kind >= 60 && kind < 75) begin
                add_segment(($urandom_range(1) == 0) ? frame_marker() : filler_marker(),
                            16'($urandom_range(1)), 8'h00, 16'h0000, 16'h0000, 8'h00);
            end else begin
                idx = $urandom_range(9);
                if (idx < 6 || kind >= 75) begin
                    len = ($urandom_range(5) == 0) ? 16'($urandom_range(7, 2))
                                                   : 16'($urandom_range(14, 8));
                    add_segment(frame_marker(), len, 8'($urandom_range(255)),
                                16'($urandom), 16'($urandom), 8'($urandom_range(255)));
                end else if (idx < 8) begin
                    image_q.push_back(MARK_PREFIX);
                    image_q.push_back(MARK_SOI + 8'($urandom_range(2)));
                    image_q.push_back(8'($urandom_range(255)));
                end
            end

            // Flip one bit of the signature.
            if (kind >= 75) begin
                idx = $urandom_range(2);
                image_q[idx] = image_q[idx] ^ 8'(1 << $urandom_range(7));
            end
        end

        // Trailing bytes, ignored once the outcome is known.
        repeat ($urandom_range(3)) image_q.push_back(8'($urandom_range(255)));

        // Cut some well-formed buffers short at a random point.
        if (kind < 60 && $urandom_range(3) == 0) begin
            cut = $urandom_range(image_q.size(), 1);
            while (image_q.size() > cut) void'(image_q.pop_back());
        end
    endtask

    // Stimulus in three idle profiles, then drain and verdict.
    initial begin
        int ph;
        int image_count;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    idle_pct  = 12;
                    stall_pct = 70;
                end
                1: begin
                    idle_pct  = 70;
                    stall_pct = 12;
                end
                default: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            byte_count  = 0;
            image_count = 0;

            if (ph == 0) begin
                // Frame start with every captured field at its maximum, then at zero.
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h08,
                            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
                send_image();
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h08,
                            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
                send_image();
                // Buffers shorter than the signature.
                image_q = '{8'h00};
                send_image();
                image_q = '{8'hFF, 8'hD8};
                send_image();
                // Signature mismatch with ignored bytes behind it.
                image_q = '{8'hFF, 8'hD9, 8'h12, 8'h34};
                send_image();
                // Start of scan stops the walk.
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'hDA, 8'h55, 8'h66};
                send_image();
                // Stop marker that is also the final byte.
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'hD9};
                send_image();
                // Lengths one and zero.
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h01};
                send_image();
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'hC4, 8'h00, 8'h00, 8'h77};
                send_image();
                // Frame start too short to hold its fields.
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'hC1, 8'h00, 8'h05, 8'h08, 8'h01, 8'h02};
                send_image();
                // Restart marker, stray byte and fill bytes before a frame start.
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'hD3, 8'h12, 8'hFF, 8'hFF, 8'hFF, 8'hC3,
                            8'h00, 8'h09, 8'h0C, 8'h01, 8'hE0, 8'h02, 8'h80, 8'h03, 8'hAA};
                send_image();
                // Marker zero carries a length like any other segment.
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h04, 8'hAA, 8'hBB,
                            8'hFF, 8'hCF, 8'h00, 8'h02};
                send_image();
                // Largest length, cut short inside the segment.
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03};
                send_image();
                // Final byte completes an ordinary segment.
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h03, 8'h55};
                send_image();
                // Final byte in a run of fill bytes, and on the third signature byte.
                image_q = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h02, 8'hFF, 8'hFF};
                send_image();
                image_q = '{8'hFF, 8'hD8, 8'hFF};
                send_image();
            end

            while (byte_count < 220 || image_count < 4) begin
                build_random_image();
                send_image();
                image_count++;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
